>>> design/complex_arithmetic_unit_defines.svh
// assertion macros for the complex arithmetic unit
// used by the rtl files that carry concurrent checks; needs clk and rst_n in scope
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> design/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // control bits that travel with each item down the pipeline
  typedef struct packed {
    logic vld;
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } ctl_t;

endpackage

>>> design/complex_arithmetic_unit.sv
// complex arithmetic unit top level: front end, divider cell row, saturation
// depends on cau_pkg, cau_front, cau_cell and complex_arithmetic_unit_defines.svh
//
//   channel | dir | fields
//   in_     | in  | tuser: req_type; tdata: a_re, a_im, b_re, b_im
//   out_    | out | tdata: res_re, res_im, status
//
// one item enters per cycle while the output is not stalled
// the row of DATA_WIDTH division cells settles one quotient bit each
// every item runs through the full pipeline, whatever its operation
// synchronous active-low reset clears the valid bits and control words only
// a stalled output holds the whole pipeline; in_tready = !out_tvalid || out_tready
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  localparam int IW = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OW = ((2 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [IW-1:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [1:0]    in_tuser,   // req_type
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [OW-1:0] out_tdata   // res_re, res_im, status
);
  localparam int W     = DATA_WIDTH;
  localparam int REM_W = 3 * W + FRAC_BITS;
  localparam int SW    = 2 * W + 2;
  localparam logic signed [SW-1:0] MAX_V = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MIN_V = -MAX_V - SW'(1);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // chain taps: index 0 comes from the front end, but the quotient taps start at zero
  cau_pkg::ctl_t       ctl_c    [W+1];
  logic [REM_W-1:0]    rem_re_c [W+1];
  logic [REM_W-1:0]    rem_im_c [W+1];
  logic [W-1:0]        q_re_c   [W+1];
  logic [W-1:0]        q_im_c   [W+1];
  logic [2*W-1:0]      den_c    [W+1];

  cau_front #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .REM_W      (REM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_op    (in_tuser),
    .a_re     ($signed(in_tdata[W-1:0])),
    .a_im     ($signed(in_tdata[2*W-1:W])),
    .b_re     ($signed(in_tdata[3*W-1:2*W])),
    .b_im     ($signed(in_tdata[4*W-1:3*W])),
    .ctl_o    (ctl_c[0]),
    .rem_re_o (rem_re_c[0]),
    .rem_im_o (rem_im_c[0]),
    .den_o    (den_c[0])
  );

  assign q_re_c[0] = '0;
  assign q_im_c[0] = '0;

  // row of division cells, most significant quotient bit first
  for (genvar i = 0; i < W; i++) begin : g_cell
    cau_cell #(
      .DATA_WIDTH (W),
      .REM_W      (REM_W),
      .SHIFT      (W - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (ctl_c[i]),
      .rem_re_i (rem_re_c[i]),
      .rem_im_i (rem_im_c[i]),
      .q_re_i   (q_re_c[i]),
      .q_im_i   (q_im_c[i]),
      .den_i    (den_c[i]),
      .ctl_o    (ctl_c[i+1]),
      .rem_re_o (rem_re_c[i+1]),
      .rem_im_o (rem_im_c[i+1]),
      .q_re_o   (q_re_c[i+1]),
      .q_im_o   (q_im_c[i+1]),
      .den_o    (den_c[i+1])
    );
  end

  // signed result values, then saturation
  cau_pkg::ctl_t        ctl_l;
  logic [W:0]           mag_re, mag_im;
  logic signed [SW-1:0] v_re, v_im;
  logic signed [W-1:0]  res_re_nxt, res_im_nxt;
  logic                 sat_re, sat_im;
  cau_pkg::status_t     status_nxt;

  always_comb begin
    ctl_l  = ctl_c[W];
    mag_re = ctl_l.ovf_re ? ((W+1)'(1) << W) : {1'b0, q_re_c[W]};
    mag_im = ctl_l.ovf_im ? ((W+1)'(1) << W) : {1'b0, q_im_c[W]};
    if (ctl_l.is_div) begin
      v_re = ctl_l.neg_re ? -$signed(SW'(mag_re)) : $signed(SW'(mag_re));
      v_im = ctl_l.neg_im ? -$signed(SW'(mag_im)) : $signed(SW'(mag_im));
    end else begin
      v_re = $signed(rem_re_c[W][SW-1:0]);
      v_im = $signed(rem_im_c[W][SW-1:0]);
    end
    sat_re = (v_re > MAX_V) || (v_re < MIN_V);
    sat_im = (v_im > MAX_V) || (v_im < MIN_V);
    res_re_nxt = (v_re > MAX_V) ? W'(MAX_V) : (v_re < MIN_V) ? W'(MIN_V) : W'(v_re);
    res_im_nxt = (v_im > MAX_V) ? W'(MAX_V) : (v_im < MIN_V) ? W'(MIN_V) : W'(v_im);
    status_nxt = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    if (ctl_l.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = cau_pkg::ST_DZ;
    end
  end

  // output register
  logic                out_vld_r;
  logic signed [W-1:0] res_re_r, res_im_r;
  cau_pkg::status_t    status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_l.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OW'({status_r, res_im_r, res_re_r});

  // checks
  `CAU_ASSERT(a_dz_zero, (out_tvalid && status_r == cau_pkg::ST_DZ) |-> (res_re_r == '0 && res_im_r == '0), "division by zero result not zero")
  `CAU_ASSERT(a_status_code, out_tvalid |-> (status_r == cau_pkg::ST_OK || status_r == cau_pkg::ST_SAT || status_r == cau_pkg::ST_DZ), "illegal status code")
  `CAU_ASSERT(a_div_flags, (ctl_l.vld && ctl_l.dz) |-> !ctl_l.is_div, "zero divisor marked for division")
  `CAU_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

>>> design/cau_front.sv
// front end: operand register, products, sums and divider set-up
// depends on cau_pkg
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int REM_W      = 3 * DATA_WIDTH + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [1:0]                    in_op,
  input  logic signed [DATA_WIDTH-1:0]  a_re,
  input  logic signed [DATA_WIDTH-1:0]  a_im,
  input  logic signed [DATA_WIDTH-1:0]  b_re,
  input  logic signed [DATA_WIDTH-1:0]  b_im,
  output cau_pkg::ctl_t                 ctl_o,
  output logic [REM_W-1:0]              rem_re_o,
  output logic [REM_W-1:0]              rem_im_o,
  output logic [2*DATA_WIDTH-1:0]       den_o
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 1;

  // stage 1: operand register
  logic                 vld1_r;
  cau_pkg::op_t         op1_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= cau_pkg::op_t'(in_op);
      ar1_r <= a_re;
      ai1_r <= a_im;
      br1_r <= b_re;
      bi1_r <= b_im;
    end
  end

  // stage 2: partial products and plain sums
  logic                 vld2_r;
  cau_pkg::op_t         op2_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, n_r_r, n_i_r;
  logic signed [W:0]    s_re_r, s_im_r;
  logic signed [W:0]    s_re_nxt, s_im_nxt;

  always_comb begin
    if (op1_r == cau_pkg::OP_SUB) begin
      s_re_nxt = (W+1)'(ar1_r) - (W+1)'(br1_r);
      s_im_nxt = (W+1)'(ai1_r) - (W+1)'(bi1_r);
    end else begin
      s_re_nxt = (W+1)'(ar1_r) + (W+1)'(br1_r);
      s_im_nxt = (W+1)'(ai1_r) + (W+1)'(bi1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      p_rr_r <= PW'(ar1_r) * PW'(br1_r);
      p_ii_r <= PW'(ai1_r) * PW'(bi1_r);
      p_ri_r <= PW'(ar1_r) * PW'(bi1_r);
      p_ir_r <= PW'(ai1_r) * PW'(br1_r);
      n_r_r  <= PW'(br1_r) * PW'(br1_r);
      n_i_r  <= PW'(bi1_r) * PW'(bi1_r);
      s_re_r <= s_re_nxt;
      s_im_r <= s_im_nxt;
    end
  end

  // stage 3: combine products into results or dividends
  logic                 vld3_r;
  cau_pkg::op_t         op3_r;
  logic signed [VW-1:0] v_re_r, v_im_r, v_re_nxt, v_im_nxt;
  logic [PW-1:0]        norm_r;
  logic signed [VW-1:0] t_re, t_im;

  always_comb begin
    t_re = '0;
    t_im = '0;
    case (op2_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        v_re_nxt = VW'(s_re_r);
        v_im_nxt = VW'(s_im_r);
      end
      cau_pkg::OP_MUL: begin
        t_re = VW'(p_rr_r) - VW'(p_ii_r);
        t_im = VW'(p_ri_r) + VW'(p_ir_r);
        v_re_nxt = t_re >>> FRAC_BITS;
        v_im_nxt = t_im >>> FRAC_BITS;
      end
      default: begin
        v_re_nxt = VW'(p_rr_r) + VW'(p_ii_r);
        v_im_nxt = VW'(p_ir_r) - VW'(p_ri_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r  <= op2_r;
      v_re_r <= v_re_nxt;
      v_im_r <= v_im_nxt;
      norm_r <= PW'($unsigned(n_r_r)) + PW'($unsigned(n_i_r));
    end
  end

  // stage 4: dividend magnitudes, shifted, and quotient overflow check
  logic [VW-1:0]     mag_re, mag_im;
  logic [REM_W-1:0]  num_re, num_im, den_top;
  cau_pkg::ctl_t     ctl_nxt;
  logic [REM_W-1:0]  rem_re_nxt, rem_im_nxt;
  logic              is_div;

  always_comb begin
    is_div  = (op3_r == cau_pkg::OP_DIV);
    mag_re  = v_re_r[VW-1] ? VW'(-v_re_r) : VW'(v_re_r);
    mag_im  = v_im_r[VW-1] ? VW'(-v_im_r) : VW'(v_im_r);
    num_re  = REM_W'(mag_re[PW-1:0]) << FRAC_BITS;
    num_im  = REM_W'(mag_im[PW-1:0]) << FRAC_BITS;
    den_top = REM_W'(norm_r) << W;
    ctl_nxt.vld    = vld3_r;
    ctl_nxt.is_div = is_div && (norm_r != '0);
    ctl_nxt.dz     = is_div && (norm_r == '0);
    ctl_nxt.neg_re = v_re_r[VW-1];
    ctl_nxt.neg_im = v_im_r[VW-1];
    ctl_nxt.ovf_re = num_re >= den_top;
    ctl_nxt.ovf_im = num_im >= den_top;
    if (is_div) begin
      rem_re_nxt = num_re;
      rem_im_nxt = num_im;
    end else begin
      rem_re_nxt = REM_W'(v_re_r);
      rem_im_nxt = REM_W'(v_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_o <= rem_re_nxt;
      rem_im_o <= rem_im_nxt;
      den_o    <= norm_r;
    end
  end

endmodule

>>> design/cau_cell.sv
// one restoring-division cell: settles one quotient bit for both parts
// depends on cau_pkg; non-divide items pass through unchanged
module cau_cell #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int REM_W      = 3 * DATA_WIDTH + cau_pkg::FRAC_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cau_pkg::ctl_t             ctl_i,
  input  logic [REM_W-1:0]          rem_re_i,
  input  logic [REM_W-1:0]          rem_im_i,
  input  logic [DATA_WIDTH-1:0]     q_re_i,
  input  logic [DATA_WIDTH-1:0]     q_im_i,
  input  logic [2*DATA_WIDTH-1:0]   den_i,
  output cau_pkg::ctl_t             ctl_o,
  output logic [REM_W-1:0]          rem_re_o,
  output logic [REM_W-1:0]          rem_im_o,
  output logic [DATA_WIDTH-1:0]     q_re_o,
  output logic [DATA_WIDTH-1:0]     q_im_o,
  output logic [2*DATA_WIDTH-1:0]   den_o
);
  logic [REM_W-1:0]      dsh;
  logic                  take_re, take_im;
  logic [REM_W-1:0]      rem_re_nxt, rem_im_nxt;
  logic [DATA_WIDTH-1:0] q_re_nxt, q_im_nxt;

  // trial subtract of the divisor at this bit weight
  always_comb begin
    dsh        = REM_W'(den_i) << SHIFT;
    take_re    = ctl_i.is_div && (rem_re_i >= dsh);
    take_im    = ctl_i.is_div && (rem_im_i >= dsh);
    rem_re_nxt = take_re ? rem_re_i - dsh : rem_re_i;
    rem_im_nxt = take_im ? rem_im_i - dsh : rem_im_i;
    q_re_nxt   = q_re_i;
    q_im_nxt   = q_im_i;
    q_re_nxt[SHIFT] = take_re;
    q_im_nxt[SHIFT] = take_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_o <= rem_re_nxt;
      rem_im_o <= rem_im_nxt;
      q_re_o   <= q_re_nxt;
      q_im_o   <= q_im_nxt;
      den_o    <= den_i;
    end
  end

endmodule

>>> dv/tb_complex_arithmetic_unit.sv
// self-checking testbench for the complex arithmetic unit: add, sub, mul, div on Q7.8 operands
// depends on cau_pkg and the complex_arithmetic_unit rtl; a scoreboard class holds expected results
module tb_complex_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int N_RANDOM = 1350;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    cau_pkg::status_t st;
  } cplx_res_t;

  // expected results of the alu, oldest first
  class cplx_scoreboard;
    cplx_res_t pending[$];
    int mismatches;

    function logic [DW-1:0] clamp(longint v, ref bit sat);
      if (v > 32767) begin
        sat = 1'b1;
        return 16'h7fff;
      end
      if (v < -32768) begin
        sat = 1'b1;
        return 16'h8000;
      end
      return v[DW-1:0];
    endfunction

    // truncated quotient num * 2^FB / den, sign of num
    function longint scaled_quot(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag << FB) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function void note_item(cau_pkg::op_t op, logic signed [DW-1:0] ar,
                            logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                            logic signed [DW-1:0] bi);
      longint xr, xi, yr, yi, vr, vi, norm;
      bit sat;
      cplx_res_t r;
      xr = ar; xi = ai; yr = br; yi = bi;
      sat = 1'b0;
      r.st = cau_pkg::ST_OK;
      case (op)
        cau_pkg::OP_ADD: begin
          vr = xr + yr;
          vi = xi + yi;
        end
        cau_pkg::OP_SUB: begin
          vr = xr - yr;
          vi = xi - yi;
        end
        cau_pkg::OP_MUL: begin
          vr = (xr * yr - xi * yi) >>> FB;
          vi = (xr * yi + xi * yr) >>> FB;
        end
        default: begin
          norm = yr * yr + yi * yi;
          if (norm == 0) begin
            r.re = '0;
            r.im = '0;
            r.st = cau_pkg::ST_DZ;
            pending.push_back(r);
            return;
          end
          vr = scaled_quot(yr * xr + yi * xi, norm);
          vi = scaled_quot(yr * xi - yi * xr, norm);
        end
      endcase
      r.re = clamp(vr, sat);
      r.im = clamp(vi, sat);
      if (sat) r.st = cau_pkg::ST_SAT;
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] data);
      cplx_res_t e;
      logic [1:0] st;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", data);
        return;
      end
      e = pending.pop_front();
      st = data[33:32];
      if (data[15:0] !== e.re || data[31:16] !== e.im || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                   e.re, e.im, e.st, data[15:0], data[31:16], st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;   // a_re, a_im, b_re, b_im
  logic [1:0] in_tuser;    // req_type
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;  // res_re, res_im, status

  cplx_scoreboard sb;
  int in_xfers;
  int stall_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // monitor both channels, predict on input transfer, check on output transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_item(cau_pkg::op_t'(in_tuser), in_tdata[15:0], in_tdata[31:16],
                   in_tdata[47:32], in_tdata[63:48]);
      in_xfers++;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(cau_pkg::op_t op, logic [DW-1:0] ar, logic [DW-1:0] ai,
                           logic [DW-1:0] br, logic [DW-1:0] bi);
    int target;
    target = in_xfers + 1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {bi, br, ai, ar};
    do @(negedge clk); while (in_xfers != target);
    in_tvalid = 1'b0;
  endtask

  // operand part biased toward small values and extremes
  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(3))
      0: return DW'($urandom);
      1: return DW'($urandom_range(1024) - 512);
      2: begin
        case ($urandom_range(3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return DW'(($urandom & 16'hffff) >>> $urandom_range(15));
    endcase
  endfunction

  task automatic random_items(int n);
    cau_pkg::op_t op;
    logic [DW-1:0] br, bi;
    for (int i = 0; i < n; i++) begin
      op = cau_pkg::op_t'($urandom_range(3));
      br = rand_part();
      bi = rand_part();
      if (op == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(op, rand_part(), rand_part(), br, bi);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = cau_pkg::OP_ADD;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, saturation, floor on negative products, division by zero
    send_item(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_item(cau_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
    send_item(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    send_item(cau_pkg::OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_item(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(cau_pkg::OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(cau_pkg::OP_MUL, 16'h0001, 16'h0000, 16'hffff, 16'h0000);
    send_item(cau_pkg::OP_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    send_item(cau_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
    send_item(cau_pkg::OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_item(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_item(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    send_item(cau_pkg::OP_DIV, 16'h8000, 16'h0000, 16'h0000, 16'h0001);
    send_item(cau_pkg::OP_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
    send_item(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h8000, 16'h8000);
    send_item(cau_pkg::OP_DIV, 16'h0200, 16'h0100, 16'h0100, 16'hff00);
    send_item(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'hffff, 16'h0000);
    send_item(cau_pkg::OP_DIV, 16'h0080, 16'h0000, 16'h0100, 16'h0000);
    send_item(cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0300, 16'h0000);

    // random, three idling phases
    send_idle_pct = 16;
    recv_idle_pct = 54;
    random_items(N_RANDOM / 3);
    send_idle_pct = 54;
    recv_idle_pct = 16;
    random_items(N_RANDOM / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(N_RANDOM - 2 * (N_RANDOM / 3));

    // drain
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
